/* rtl/pdxd_pkg.sv */
// shared types, constants and key table of the packet deframer with xor descrambler
package pdxd_pkg;

  localparam int unsigned DataW  = 8;
  localparam int unsigned WordW  = 16;
  localparam int unsigned KeyIdxW = 3;

  localparam logic [WordW-1:0] MinLength = 16'd4;
  localparam logic [WordW-1:0] XorFirst  = 16'd2;
  localparam logic [DataW-1:0] ScrambleMark = 8'd1;

  typedef enum logic [2:0] {
    ROLE_LEN_LO  = 3'd0,
    ROLE_LEN_HI  = 3'd1,
    ROLE_OP_LO   = 3'd2,
    ROLE_OP_HI   = 3'd3,
    ROLE_PAYLOAD = 3'd4,
    ROLE_DROPPED = 3'd5
  } role_e;

  typedef struct packed {
    logic [WordW-1:0] payload_index;
    logic [WordW-1:0] opcode_value;
    logic [DataW-1:0] data_out;
    logic             length_error;
    logic             packet_end;
    role_e            byte_role;
  } res_t;

  function automatic logic [DataW-1:0] key_byte(input logic [KeyIdxW-1:0] idx);
    logic [DataW-1:0] k;
    unique case (idx)
      3'd0: k = 8'hb1;
      3'd1: k = 8'he1;
      3'd2: k = 8'hd2;
      3'd3: k = 8'hc4;
      3'd4: k = 8'h4a;
      3'd5: k = 8'h2f;
      3'd6: k = 8'h6b;
      3'd7: k = 8'h22;
      default: k = 8'h00;
    endcase
    return k;
  endfunction

endpackage

/* rtl/pdxd_core.sv */
// framing state and per-byte role, opcode, index and descramble logic
module pdxd_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic [pdxd_pkg::DataW-1:0]     byte_i,
  input  logic                           start_i,
  output pdxd_pkg::res_t                 res_o
);

  pdxd_pkg::role_e                   phase_q, phase_d;
  logic [pdxd_pkg::WordW-1:0]        total_q, total_d;
  logic [pdxd_pkg::WordW-1:0]        opcode_q, opcode_d;
  logic [pdxd_pkg::WordW-1:0]        count_q, count_d;
  logic                              scram_q, scram_d;
  logic                              drop_q, drop_d;

  pdxd_pkg::role_e                   ph;
  logic [pdxd_pkg::WordW-1:0]        len_full;
  logic [pdxd_pkg::WordW-1:0]        op_full;
  logic [pdxd_pkg::WordW:0]          idx_ext;
  logic [pdxd_pkg::WordW:0]          tot_ext;
  logic [pdxd_pkg::KeyIdxW-1:0]      key_idx;
  logic                              in_xor;
  logic                              last_pl;

  always_comb begin
    ph       = start_i ? pdxd_pkg::ROLE_LEN_LO : phase_q;
    len_full = {byte_i, total_q[7:0]};
    op_full  = {byte_i, opcode_q[7:0]};
    idx_ext  = {1'b0, count_q};
    tot_ext  = {1'b0, total_q};
    key_idx  = count_q[pdxd_pkg::KeyIdxW-1:0] - pdxd_pkg::XorFirst[pdxd_pkg::KeyIdxW-1:0];
    in_xor   = scram_q && (count_q >= pdxd_pkg::XorFirst) && (idx_ext + 17'd7 <= tot_ext);
    last_pl  = (idx_ext + {1'b0, pdxd_pkg::MinLength} + 17'd1) >= tot_ext;

    phase_d  = ph;
    total_d  = total_q;
    opcode_d = opcode_q;
    count_d  = count_q;
    scram_d  = scram_q;
    drop_d   = drop_q & ~start_i;

    res_o.data_out      = byte_i;
    res_o.byte_role     = ph;
    res_o.opcode_value  = '0;
    res_o.payload_index = '0;
    res_o.packet_end    = 1'b0;
    res_o.length_error  = 1'b0;

    if (drop_d) begin
      res_o.byte_role = pdxd_pkg::ROLE_DROPPED;
    end else begin
      unique case (ph)
        pdxd_pkg::ROLE_LEN_LO: begin
          total_d = {8'h00, byte_i};
          phase_d = pdxd_pkg::ROLE_LEN_HI;
        end
        pdxd_pkg::ROLE_LEN_HI: begin
          total_d = len_full;
          if (len_full < pdxd_pkg::MinLength) begin
            res_o.length_error = 1'b1;
            drop_d  = 1'b1;
            phase_d = pdxd_pkg::ROLE_LEN_LO;
          end else begin
            phase_d = pdxd_pkg::ROLE_OP_LO;
          end
        end
        pdxd_pkg::ROLE_OP_LO: begin
          opcode_d = {8'h00, byte_i};
          phase_d  = pdxd_pkg::ROLE_OP_HI;
        end
        pdxd_pkg::ROLE_OP_HI: begin
          opcode_d           = op_full;
          res_o.opcode_value = op_full;
          count_d            = '0;
          scram_d            = 1'b0;
          if (total_q == pdxd_pkg::MinLength) begin
            res_o.packet_end = 1'b1;
            phase_d          = pdxd_pkg::ROLE_LEN_LO;
          end else begin
            phase_d = pdxd_pkg::ROLE_PAYLOAD;
          end
        end
        default: begin
          res_o.byte_role     = pdxd_pkg::ROLE_PAYLOAD;
          res_o.opcode_value  = opcode_q;
          res_o.payload_index = count_q;
          if (count_q == '0) begin
            scram_d = (byte_i == pdxd_pkg::ScrambleMark);
          end else if (in_xor) begin
            res_o.data_out = byte_i ^ pdxd_pkg::key_byte(key_idx);
          end
          if (last_pl) begin
            res_o.packet_end = 1'b1;
            phase_d          = pdxd_pkg::ROLE_LEN_LO;
          end
          count_d = count_q + 16'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= pdxd_pkg::ROLE_LEN_LO;
      total_q  <= '0;
      opcode_q <= '0;
      count_q  <= '0;
      scram_q  <= 1'b0;
      drop_q   <= 1'b0;
    end else if (en_i) begin
      phase_q  <= phase_d;
      total_q  <= total_d;
      opcode_q <= opcode_d;
      count_q  <= count_d;
      scram_q  <= scram_d;
      drop_q   <= drop_d;
    end
  end

endmodule

/* rtl/packet_deframer_xor_descrambler.sv */
// top level: input beat register, framing core and result register
//
//  channel  dir  tdata (low bit up)                          tuser (low bit up)   tlast
//  s_axis   in   data_in[7:0]                                 buffer_start[0]      -
//  m_axis   out  data_out[7:0] opcode_value[23:8]             byte_role[2:0]       packet_end
//                payload_index[39:24]                         length_error[3]
//
// one beat per cycle sustained while m_axis is ready
// the input register feeds the framing logic, whose result lands in the output register
// both registers advance together whenever the output register is empty or being taken
// a stalled m_axis holds both registers and drops s_axis_tready once the input one is full
// reset empties both registers and restarts framing at a length low byte
module packet_deframer_xor_descrambler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_in
  input  logic [0:0]  s_axis_tuser,   // buffer_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // data_out, opcode_value, payload_index
  output logic [3:0]  m_axis_tuser,   // byte_role, length_error
  output logic        m_axis_tlast    // packet_end
);

  logic                          in_vld_q;
  logic [pdxd_pkg::DataW-1:0]    in_byte_q;
  logic                          in_start_q;
  logic                          out_vld_q;
  pdxd_pkg::res_t                out_q;
  pdxd_pkg::res_t                res;
  logic                          adv;
  logic                          fire;

  assign adv           = !out_vld_q || m_axis_tready;
  assign fire          = adv && in_vld_q;
  assign s_axis_tready = !in_vld_q || adv;

  pdxd_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (fire),
    .byte_i  (in_byte_q),
    .start_i (in_start_q),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser[0];
    end
    if (fire) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.payload_index, out_q.opcode_value, out_q.data_out};
  assign m_axis_tuser  = {out_q.length_error, out_q.byte_role};
  assign m_axis_tlast  = out_q.packet_end;

endmodule

/* dv/tb_packet_deframer_xor_descrambler.sv */
// testbench for the packet deframer with xor descrambler: directed, random, full rate packet
module tb_packet_deframer_xor_descrambler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned RandomBeats = 1700;
  localparam int unsigned FullPacket = 32'hffff_ffff;
  localparam int unsigned ReportCap = 50;
  localparam logic [63:0] DescrambleKey = 64'h226b_2f4a_c4d2_e1b1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic [0:0]  s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // deframer state as seen from the stream
  pdxd_pkg::role_e phase_q = pdxd_pkg::ROLE_LEN_LO;
  logic [15:0] len_q = '0;
  logic [15:0] op_q = '0;
  logic [15:0] cnt_q = '0;
  logic        scr_q = 1'b0;
  logic        drop_q = 1'b0;

  pdxd_pkg::res_t expected_beats [$];
  pdxd_pkg::res_t want;
  int unsigned mismatch_count = 0;
  int unsigned beats_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned cycle_count = 0;

  bit          tx_gaps_on = 1'b1;
  int unsigned tx_burst_left = 0;
  bit          rx_stalls_on = 1'b1;
  bit          rx_ready_q = 1'b0;
  int unsigned rx_run = 0;

  packet_deframer_xor_descrambler u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic pdxd_pkg::res_t deframe_beat(input logic [7:0] din, input logic start);
    pdxd_pkg::res_t r;
    int unsigned idx;
    logic [2:0]  kidx;
    r = '0;
    r.data_out = din;
    if (start) begin
      drop_q = 1'b0;
      phase_q = pdxd_pkg::ROLE_LEN_LO;
    end
    if (drop_q) begin
      r.byte_role = pdxd_pkg::ROLE_DROPPED;
    end else begin
      r.byte_role = phase_q;
      case (phase_q)
        pdxd_pkg::ROLE_LEN_LO: begin
          len_q = {8'h00, din};
          phase_q = pdxd_pkg::ROLE_LEN_HI;
        end
        pdxd_pkg::ROLE_LEN_HI: begin
          len_q = {din, len_q[7:0]};
          if (len_q < pdxd_pkg::MinLength) begin
            r.length_error = 1'b1;
            drop_q = 1'b1;
            phase_q = pdxd_pkg::ROLE_LEN_LO;
          end else begin
            phase_q = pdxd_pkg::ROLE_OP_LO;
          end
        end
        pdxd_pkg::ROLE_OP_LO: begin
          op_q = {8'h00, din};
          phase_q = pdxd_pkg::ROLE_OP_HI;
        end
        pdxd_pkg::ROLE_OP_HI: begin
          op_q = {din, op_q[7:0]};
          r.opcode_value = op_q;
          cnt_q = '0;
          scr_q = 1'b0;
          if (len_q == pdxd_pkg::MinLength) begin
            r.packet_end = 1'b1;
            phase_q = pdxd_pkg::ROLE_LEN_LO;
          end else begin
            phase_q = pdxd_pkg::ROLE_PAYLOAD;
          end
        end
        default: begin
          idx = cnt_q;
          r.opcode_value = op_q;
          r.payload_index = cnt_q;
          r.byte_role = pdxd_pkg::ROLE_PAYLOAD;
          if (idx == 0) begin
            scr_q = (din == pdxd_pkg::ScrambleMark);
          end else if (scr_q && idx >= pdxd_pkg::XorFirst && idx + 7 <= len_q) begin
            kidx = 3'(idx - pdxd_pkg::XorFirst);
            r.data_out = din ^ DescrambleKey[8*kidx +: 8];
          end
          if (idx + pdxd_pkg::MinLength + 1 >= len_q) begin
            r.packet_end = 1'b1;
            phase_q = pdxd_pkg::ROLE_LEN_LO;
          end
          cnt_q = cnt_q + 16'd1;
        end
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] exp_val);
    if (mismatch_count < ReportCap) begin
      $display("mismatch %s at result %0d: got %h want %h", what, beats_checked, got, exp_val);
    end
    mismatch_count++;
  endtask

  // entered and left just after a falling edge
  task automatic send_beat(input logic [7:0] din, input logic start);
    if (tx_gaps_on) begin
      if (tx_burst_left == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
        tx_burst_left = $urandom_range(1, 16);
      end
      tx_burst_left--;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= din;
    s_axis_tuser  <= start;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_beats.push_back(deframe_beat(din, start));
    beats_sent++;
    @(negedge clk_i);
  endtask

  // cut limits how many payload bytes go out, for abandoned packets
  task automatic send_packet(input logic [15:0] len, input logic [15:0] op, input bit scrambled,
                             input bit start_first, input int unsigned cut);
    int unsigned n_pay;
    logic [7:0]  b;
    send_beat(len[7:0], start_first);
    send_beat(len[15:8], 1'b0);
    if (len >= pdxd_pkg::MinLength) begin
      send_beat(op[7:0], 1'b0);
      send_beat(op[15:8], 1'b0);
      n_pay = len - pdxd_pkg::MinLength;
      if (cut < n_pay) n_pay = cut;
      for (int unsigned i = 0; i < n_pay; i++) begin
        b = 8'($urandom);
        if (i == 0) begin
          b = scrambled ? pdxd_pkg::ScrambleMark
                        : ((b == pdxd_pkg::ScrambleMark) ? 8'h00 : b);
        end
        send_beat(b, 1'b0);
      end
    end
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (expected_beats.size() != 0);
  endtask

  task automatic test_directed_frames();
    // huge length abandoned by a buffer start, then a four byte packet
    send_packet(16'hffff, 16'h8001, 1'b1, 1'b1, 2);
    send_packet(16'd4, 16'hffff, 1'b0, 1'b1, FullPacket);
    // shortest length with a descrambled byte
    send_packet(16'd9, 16'h0000, 1'b1, 1'b0, FullPacket);
    // short length, then drop
    send_packet(16'd3, 16'h0000, 1'b0, 1'b0, FullPacket);
    send_beat(8'hff, 1'b0);
    // zero length ends the drop with a buffer start and starts another
    send_packet(16'd0, 16'h0000, 1'b0, 1'b1, FullPacket);
    send_beat(8'h00, 1'b0);
  endtask

  task automatic test_random_traffic();
    int unsigned first;
    int unsigned kind;
    int unsigned done;
    logic [15:0] len;
    bit          resync;
    first = beats_sent;
    done = 0;
    while (done < RandomBeats) begin
      tx_gaps_on = (done < 700) || (done >= 1000);
      rx_stalls_on = (done < 800) || (done >= 1100);
      resync = drop_q || (phase_q != pdxd_pkg::ROLE_LEN_LO);
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(49, 700))
                                          : 16'($urandom_range(4, 48));
        send_packet(len, 16'($urandom), $urandom_range(0, 2) != 0,
                    resync || ($urandom_range(0, 3) == 0), FullPacket);
      end else if (kind < 85) begin
        send_packet(16'($urandom_range(0, 3)), 16'($urandom), 1'b0,
                    resync || ($urandom_range(0, 1) == 0), FullPacket);
        repeat ($urandom_range(0, 4)) send_beat(8'($urandom), 1'b0);
      end else if (kind < 93) begin
        len = 16'($urandom_range(6, 60));
        send_packet(len, 16'($urandom), 1'b1, resync || ($urandom_range(0, 1) == 0),
                    $urandom_range(0, len - 5));
      end else begin
        repeat ($urandom_range(1, 8)) send_beat(8'($urandom), $urandom_range(0, 7) == 0);
      end
      done = beats_sent - first;
    end
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  task automatic test_full_rate_packet();
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    send_packet(16'd300, 16'($urandom), 1'b1, 1'b1, FullPacket);
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // receiver alternates ready and stall runs, or stays ready while stalls are off
  always @(negedge clk_i) begin
    if (!rx_stalls_on) begin
      m_axis_tready <= 1'b1;
    end else begin
      if (rx_run == 0) begin
        rx_ready_q = !rx_ready_q;
        rx_run = rx_ready_q ? $urandom_range(1, 12) : $urandom_range(1, 5);
      end else begin
        rx_run--;
      end
      m_axis_tready <= rx_ready_q;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("beat with nothing expected", m_axis_tdata, '0);
      end else begin
        want = expected_beats.pop_front();
        if (m_axis_tdata[7:0] !== want.data_out)
          report_mismatch("data_out", m_axis_tdata[7:0], want.data_out);
        if (m_axis_tdata[23:8] !== want.opcode_value)
          report_mismatch("opcode_value", m_axis_tdata[23:8], want.opcode_value);
        if (m_axis_tdata[39:24] !== want.payload_index)
          report_mismatch("payload_index", m_axis_tdata[39:24], want.payload_index);
        if (m_axis_tuser[2:0] !== want.byte_role)
          report_mismatch("byte_role", m_axis_tuser[2:0], want.byte_role);
        if (m_axis_tuser[3] !== want.length_error)
          report_mismatch("length_error", m_axis_tuser[3], want.length_error);
        if (m_axis_tlast !== want.packet_end)
          report_mismatch("packet_end", m_axis_tlast, want.packet_end);
      end
      beats_checked++;
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("packet_deframer_xor_descrambler verification failed");
    $finish;
  end

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_frames();
    wait_for_results();
    test_random_traffic();
    wait_for_results();
    test_full_rate_packet();
    wait_for_results();
    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("packet_deframer_xor_descrambler verification clean");
    end else begin
      $display("packet_deframer_xor_descrambler verification failed");
    end
    $finish;
  end

endmodule
